// ----- hdl/rrc_pkg.sv -----
package rrc_pkg;

    // Frame, ray and radius limits
    localparam int IMG_W      = 256;
    localparam int IMG_H      = 256;
    localparam int RAY_COUNT  = 720;
    localparam int MAX_RADIUS = 511;

    // Rays per octant; directions repeat by symmetry every octant
    localparam int OCT_STEPS = RAY_COUNT / 8;

    localparam int XW  = $clog2(IMG_W);
    localparam int YW  = $clog2(IMG_H);
    localparam int RW  = $clog2(MAX_RADIUS + 1);
    localparam int KW  = $clog2(RAY_COUNT);
    localparam int IW  = $clog2(OCT_STEPS + 1);
    localparam int CW  = $clog2(RAY_COUNT + 1);
    localparam int PW  = 27;
    localparam int NW  = 26;
    localparam int DW  = 13;

    localparam longint unsigned ONE_Q30        = 64'd1073741824;
    localparam longint unsigned QUARTER_PI_Q30 = 64'd843314857;

    // Configuration register indexes
    localparam logic [2:0] CFG_CENTRE_X     = 3'd0;
    localparam logic [2:0] CFG_CENTRE_Y     = 3'd1;
    localparam logic [2:0] CFG_SPAN         = 3'd2;
    localparam logic [2:0] CFG_DOUBLES_LOW  = 3'd3;
    localparam logic [2:0] CFG_DOUBLES_HIGH = 3'd4;
    localparam logic [2:0] CFG_TREBLES_LOW  = 3'd5;
    localparam logic [2:0] CFG_TREBLES_HIGH = 3'd6;
    localparam logic [2:0] CFG_SKIP         = 3'd7;

    // Result codes
    localparam logic [1:0] ST_MEASURED = 2'd0;
    localparam logic [1:0] ST_FEW_RAYS = 2'd1;
    localparam logic [1:0] ST_BYPASSED = 2'd2;
    localparam logic [1:0] ST_SPAN_0   = 2'd3;

    localparam logic [1:0] KIND_UNKNOWN = 2'd0;
    localparam logic [1:0] KIND_DOUBLES = 2'd1;
    localparam logic [1:0] KIND_TREBLES = 2'd2;

    localparam logic MODE_LOAD = 1'b0;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_RAY_DIR,
        S_SETUP_X,
        S_SETUP_Y,
        S_SCAN_ADDR,
        S_SCAN_READ,
        S_HIST_RD,
        S_HIST_WR,
        S_RAYS_DONE,
        S_RANK,
        S_WALK_RD,
        S_WALK_CHK,
        S_DIV_START,
        S_DIV_WAIT,
        S_FINISH
    } t_state;

    // Ray generator commands
    typedef struct packed {
        logic first;
        logic next;
        logic load_dir;
        logic setup_x;
        logic setup_y;
        logic step;
    } t_ray_ctl;

    typedef logic [14:0] t_mag_tab [0:OCT_STEPS];

    // Integer Taylor series in Q30, evaluated at elaboration only
    function automatic longint taylor_q30(longint unsigned x, bit sine);
        longint unsigned x2;
        longint unsigned t;
        longint acc;
        x2  = (x * x) >> 30;
        t   = sine ? x : ONE_Q30;
        acc = longint'(t);
        for (int n = 1; n <= 6; n++) begin
            t = (t * x2) >> 30;
            case (n)
                1: t = sine ? t / 6   : t / 2;
                2: t = sine ? t / 20  : t / 12;
                3: t = sine ? t / 42  : t / 30;
                4: t = sine ? t / 72  : t / 56;
                5: t = sine ? t / 110 : t / 90;
                default: t = sine ? t / 156 : t / 132;
            endcase
            if (n % 2 == 1) begin
                acc = acc - longint'(t);
            end else begin
                acc = acc + longint'(t);
            end
        end
        return acc;
    endfunction

    // Q30 to Q0.15 magnitude, rounded half up, saturated
    function automatic logic [14:0] mag_q15(longint v);
        longint unsigned m;
        m = (v < 0) ? 64'd0 : longint'(v);
        m = (m + 64'd16384) >> 15;
        if (m > 64'd32767) begin
            m = 64'd32767;
        end
        return m[14:0];
    endfunction

    function automatic t_mag_tab build_tab(bit sine);
        t_mag_tab tab;
        longint unsigned x;
        for (int i = 0; i <= OCT_STEPS; i++) begin
            x      = longint'(i) * QUARTER_PI_Q30 / OCT_STEPS;
            tab[i] = mag_q15(taylor_q30(x, sine));
        end
        return tab;
    endfunction

    localparam t_mag_tab SIN_TAB = build_tab(1'b1);
    localparam t_mag_tab COS_TAB = build_tab(1'b0);

endpackage

// ----- hdl/radial_reach_ring_classifier_core.sv -----
// Channel | Ports                                         | Handshake
// --------+-----------------------------------------------+---------------------------
// item in | i_mode i_pixel_x i_pixel_y i_pixel_on         | i_start high, o_busy low
// result  | o_status o_ring_kind o_reach_ratio o_rays_... | o_done high for one cycle
// config  | i_cfg_addr i_cfg_data                         | i_cfg_we high
//
// A load item leaves o_busy low, so loads stream every cycle while no run is in progress.
// A run clears the 512 histogram entries, then per ray sets up direction, x and y,
// scans radii inward over the mask and on a hit updates the histogram, then walks
// the histogram and divides; the ray scan over the single mask read port dominates.
// Bypass and span-zero runs go straight to the finish. Reset is synchronous, active low.
// The receiver cannot stall: o_done marks each result for exactly one cycle.
module radial_reach_ring_classifier_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic        i_mode,
    input  logic [7:0]  i_pixel_x,
    input  logic [7:0]  i_pixel_y,
    input  logic        i_pixel_on,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_data,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic [1:0]  o_ring_kind,
    output logic [15:0] o_reach_ratio,
    output logic [9:0]  o_rays_answered
);
    import rrc_pkg::*;

    localparam int AW = XW + YW;

    // Configuration
    logic [11:0] r_centre_x;
    logic [11:0] r_centre_y;
    logic [11:0] r_span;
    logic [15:0] r_dbl_lo;
    logic [15:0] r_dbl_hi;
    logic [15:0] r_tre_lo;
    logic [15:0] r_tre_hi;
    logic        r_skip;

    // Sequencer state and datapath
    t_state        r_state, n_state;
    logic [RW-1:0] r_haddr, n_haddr;
    logic [RW-1:0] r_radius, n_radius;
    logic [RW-1:0] r_rmax, n_rmax;
    logic [16:0]   r_rmax_num, n_rmax_num;
    logic [KW-1:0] r_ray, n_ray;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_rank, n_rank;
    logic [CW:0]   r_cum, n_cum;
    logic [RW-1:0] r_rad, n_rad;
    logic [1:0]    r_status, n_status;
    logic [15:0]   r_reach, n_reach;
    logic          r_done, n_done;
    logic [1:0]    r_kind, n_kind;

    // Memories
    logic            mask_mem [0:IMG_W*IMG_H-1];
    logic            r_mask_q;
    logic [CW-1:0]   hist_mem [0:MAX_RADIUS];
    logic [CW-1:0]   r_hist_q;

    t_ray_ctl      ray_ctl;
    logic          in_frame;
    logic [AW-1:0] pix_addr;
    logic          accept;
    logic          div_start;
    logic          div_done;
    logic [NW-1:0] div_quo;
    logic [NW-1:0] div_num;
    logic [CW:0]   walk_sum;
    logic [29:0]   rmax_prod;
    logic [11:0]   rmax_q;
    logic [12:0]   rank_num;
    logic [28:0]   rank_prod;
    logic          last_ray;
    logic          hist_we;
    logic [CW-1:0] hist_wd;

    assign accept = i_start && (r_state == S_IDLE);
    assign o_busy = (r_state != S_IDLE);

    rrc_ray_gen u_ray (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ray_ctl),
        .i_centre_x (r_centre_x),
        .i_centre_y (r_centre_y),
        .i_rmax     (r_rmax),
        .o_in_frame (in_frame),
        .o_addr     (pix_addr)
    );

    assign div_num = NW'({r_rad, 17'b0}) + NW'(r_span);

    rrc_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   ({r_span, 1'b0}),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_centre_x <= 12'd2048;
            r_centre_y <= 12'd2048;
            r_span     <= 12'd0;
            r_dbl_lo   <= 16'd3250;
            r_dbl_hi   <= 16'd5163;
            r_tre_lo   <= 16'd5164;
            r_tre_hi   <= 16'd8204;
            r_skip     <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_CENTRE_X:     r_centre_x <= i_cfg_data[11:0];
                CFG_CENTRE_Y:     r_centre_y <= i_cfg_data[11:0];
                CFG_SPAN:         r_span     <= i_cfg_data[11:0];
                CFG_DOUBLES_LOW:  r_dbl_lo   <= i_cfg_data;
                CFG_DOUBLES_HIGH: r_dbl_hi   <= i_cfg_data;
                CFG_TREBLES_LOW:  r_tre_lo   <= i_cfg_data;
                CFG_TREBLES_HIGH: r_tre_hi   <= i_cfg_data;
                default:          r_skip     <= i_cfg_data[0];
            endcase
        end
    end

    // Mask store: one write port for loads, one registered read for scans
    always_ff @(posedge i_clk) begin
        if (accept && (i_mode == MODE_LOAD)) begin
            mask_mem[{i_pixel_y[YW-1:0], i_pixel_x[XW-1:0]}] <= i_pixel_on;
        end
        r_mask_q <= mask_mem[pix_addr];
    end

    // Radius histogram
    always_ff @(posedge i_clk) begin
        if (hist_we) begin
            hist_mem[r_haddr] <= hist_wd;
        end
        r_hist_q <= hist_mem[r_haddr];
    end

    // Shared arithmetic helpers
    always_comb begin
        rmax_prod = r_rmax_num[16:5] * 18'd52429;
        rmax_q    = rmax_prod[29:18];
        rank_num  = 13'(9 * (r_count - 1'b1)) + 13'd5;
        rank_prod = rank_num * 16'd52429;
        walk_sum  = r_cum + (CW+1)'(r_hist_q);
        last_ray  = (r_ray == KW'(RAY_COUNT - 1));
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && (i_mode != MODE_LOAD)) begin
                    if (r_skip || (r_span == '0)) begin
                        n_state = S_FINISH;
                    end else begin
                        n_state = S_CLEAR;
                    end
                end
            end
            S_CLEAR: begin
                if (r_haddr == RW'(MAX_RADIUS)) begin
                    n_state = S_RAY_DIR;
                end
            end
            S_RAY_DIR: n_state = S_SETUP_X;
            S_SETUP_X: n_state = S_SETUP_Y;
            S_SETUP_Y: begin
                if (r_rmax == '0) begin
                    n_state = last_ray ? S_RAYS_DONE : S_RAY_DIR;
                end else begin
                    n_state = S_SCAN_ADDR;
                end
            end
            S_SCAN_ADDR: begin
                if (in_frame) begin
                    n_state = S_SCAN_READ;
                end else if (r_radius == RW'(1)) begin
                    n_state = last_ray ? S_RAYS_DONE : S_RAY_DIR;
                end
            end
            S_SCAN_READ: begin
                if (r_mask_q) begin
                    n_state = S_HIST_RD;
                end else if (r_radius == RW'(1)) begin
                    n_state = last_ray ? S_RAYS_DONE : S_RAY_DIR;
                end else begin
                    n_state = S_SCAN_ADDR;
                end
            end
            S_HIST_RD: n_state = S_HIST_WR;
            S_HIST_WR: n_state = last_ray ? S_RAYS_DONE : S_RAY_DIR;
            S_RAYS_DONE: begin
                if ({r_count, 1'b0} < (CW+1)'(RAY_COUNT)) begin
                    n_state = S_FINISH;
                end else begin
                    n_state = S_RANK;
                end
            end
            S_RANK:    n_state = S_WALK_RD;
            S_WALK_RD: n_state = S_WALK_CHK;
            S_WALK_CHK: begin
                if ((walk_sum > (CW+1)'(r_rank)) || (r_haddr == RW'(MAX_RADIUS))) begin
                    n_state = S_DIV_START;
                end else begin
                    n_state = S_WALK_RD;
                end
            end
            S_DIV_START: n_state = S_DIV_WAIT;
            S_DIV_WAIT: begin
                if (div_done) begin
                    n_state = S_FINISH;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and control outputs
    always_comb begin
        n_haddr    = r_haddr;
        n_radius   = r_radius;
        n_rmax     = r_rmax;
        n_rmax_num = r_rmax_num;
        n_ray      = r_ray;
        n_count    = r_count;
        n_rank     = r_rank;
        n_cum      = r_cum;
        n_rad      = r_rad;
        n_status   = r_status;
        n_reach    = r_reach;
        n_kind     = r_kind;
        n_done     = 1'b0;
        ray_ctl    = '0;
        hist_we    = 1'b0;
        hist_wd    = '0;
        div_start  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept && (i_mode != MODE_LOAD)) begin
                    n_count    = '0;
                    n_reach    = '0;
                    n_kind     = KIND_UNKNOWN;
                    n_haddr    = '0;
                    n_ray      = '0;
                    n_rmax_num = 17'(21 * r_span) + 17'd80;
                    ray_ctl.first = 1'b1;
                    if (r_skip) begin
                        n_status = ST_BYPASSED;
                    end else if (r_span == '0) begin
                        n_status = ST_SPAN_0;
                    end else begin
                        n_status = ST_MEASURED;
                    end
                end
            end
            S_CLEAR: begin
                hist_we = 1'b1;
                n_haddr = r_haddr + 1'b1;
                n_rmax  = (rmax_q > 12'(MAX_RADIUS)) ? RW'(MAX_RADIUS) : rmax_q[RW-1:0];
            end
            S_RAY_DIR: ray_ctl.load_dir = 1'b1;
            S_SETUP_X: begin
                ray_ctl.setup_x = 1'b1;
                n_radius        = r_rmax;
            end
            S_SETUP_Y: begin
                ray_ctl.setup_y = 1'b1;
                if (r_rmax == '0) begin
                    ray_ctl.next = 1'b1;
                    n_ray        = r_ray + 1'b1;
                end
            end
            S_SCAN_ADDR: begin
                if (!in_frame) begin
                    if (r_radius == RW'(1)) begin
                        ray_ctl.next = 1'b1;
                        n_ray        = r_ray + 1'b1;
                    end else begin
                        ray_ctl.step = 1'b1;
                        n_radius     = r_radius - 1'b1;
                    end
                end
            end
            S_SCAN_READ: begin
                if (r_mask_q) begin
                    n_count = r_count + 1'b1;
                    n_haddr = r_radius;
                end else if (r_radius == RW'(1)) begin
                    ray_ctl.next = 1'b1;
                    n_ray        = r_ray + 1'b1;
                end else begin
                    ray_ctl.step = 1'b1;
                    n_radius     = r_radius - 1'b1;
                end
            end
            S_HIST_RD: begin
            end
            S_HIST_WR: begin
                hist_we      = 1'b1;
                hist_wd      = r_hist_q + 1'b1;
                ray_ctl.next = 1'b1;
                n_ray        = r_ray + 1'b1;
            end
            S_RAYS_DONE: begin
                if ({r_count, 1'b0} < (CW+1)'(RAY_COUNT)) begin
                    n_status = ST_FEW_RAYS;
                end
            end
            S_RANK: begin
                n_rank  = rank_prod[19+CW-1:19];
                n_haddr = RW'(1);
                n_cum   = '0;
            end
            S_WALK_RD: begin
            end
            S_WALK_CHK: begin
                if (walk_sum > (CW+1)'(r_rank)) begin
                    n_rad = r_haddr;
                end else if (r_haddr == RW'(MAX_RADIUS)) begin
                    n_rad = '0;
                end else begin
                    n_haddr = r_haddr + 1'b1;
                    n_cum   = walk_sum;
                end
            end
            S_DIV_START: div_start = 1'b1;
            S_DIV_WAIT: begin
                if (div_done) begin
                    n_reach = (div_quo[NW-1:16] != '0) ? 16'hFFFF : div_quo[15:0];
                end
            end
            default: begin
                // Finish: classify a measured reach and present the result
                n_done = 1'b1;
                if (r_status == ST_MEASURED) begin
                    if ((r_reach >= r_dbl_lo) && (r_reach < r_dbl_hi)) begin
                        n_kind = KIND_DOUBLES;
                    end else if ((r_reach >= r_tre_lo) && (r_reach < r_tre_hi)) begin
                        n_kind = KIND_TREBLES;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_haddr    <= n_haddr;
        r_radius   <= n_radius;
        r_rmax     <= n_rmax;
        r_rmax_num <= n_rmax_num;
        r_ray      <= n_ray;
        r_rank     <= n_rank;
        r_cum      <= n_cum;
        r_rad      <= n_rad;
        r_status   <= n_status;
        r_reach    <= n_reach;
        r_kind     <= n_kind;
    end

    assign o_done          = r_done;
    assign o_status        = r_status;
    assign o_ring_kind     = r_kind;
    assign o_reach_ratio   = r_reach;
    assign o_rays_answered = r_count;

endmodule

// ----- hdl/rrc_divider.sv -----
module rrc_divider (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [rrc_pkg::NW-1:0] i_num,
    input  logic [rrc_pkg::DW-1:0] i_den,
    output logic                  o_done,
    output logic [rrc_pkg::NW-1:0] o_quo
);
    import rrc_pkg::*;

    localparam int SW = $clog2(NW + 1);

    logic [NW-1:0] r_quo;
    logic [DW:0]   r_rem;
    logic [DW-1:0] r_den;
    logic [SW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [DW:0]   shifted;
    logic [DW+1:0] trial;

    // Restoring division, one quotient bit a cycle
    always_comb begin
        shifted = {r_rem[DW-1:0], r_quo[NW-1]};
        trial   = {1'b0, shifted} - {2'b00, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_quo  <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                if (trial[DW+1]) begin
                    r_rem <= shifted;
                    r_quo <= {r_quo[NW-2:0], 1'b0};
                end else begin
                    r_rem <= trial[DW:0];
                    r_quo <= {r_quo[NW-2:0], 1'b1};
                end
                if (r_cnt == SW'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// ----- hdl/rrc_ray_gen.sv -----
module rrc_ray_gen (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  rrc_pkg::t_ray_ctl      i_ctl,
    input  logic [11:0]            i_centre_x,
    input  logic [11:0]            i_centre_y,
    input  logic [rrc_pkg::RW-1:0] i_rmax,
    output logic                   o_in_frame,
    output logic [rrc_pkg::XW+rrc_pkg::YW-1:0] o_addr
);
    import rrc_pkg::*;

    logic [2:0]             r_oct;
    logic [IW-1:0]          r_rem;
    logic signed [15:0]     r_dir_c;
    logic signed [15:0]     r_dir_s;
    logic signed [PW-1:0]   r_px;
    logic signed [PW-1:0]   r_py;

    logic [IW-1:0]          idx;
    logic [14:0]            sb;
    logic [14:0]            cb;
    logic signed [15:0]     n_dir_c;
    logic signed [15:0]     n_dir_s;
    logic signed [15:0]     mul_dir;
    logic [11:0]            mul_centre;
    logic signed [PW-1:0]   setup_p;
    logic                   in_x;
    logic                   in_y;

    // Direction from the octant table by symmetry
    always_comb begin
        if (!r_oct[0]) begin
            idx = r_rem;
            sb  = SIN_TAB[idx];
            cb  = COS_TAB[idx];
        end else begin
            idx = IW'(OCT_STEPS) - r_rem;
            sb  = COS_TAB[idx];
            cb  = SIN_TAB[idx];
        end
        case (r_oct[2:1])
            2'd0: begin
                n_dir_c = $signed({1'b0, cb});
                n_dir_s = $signed({1'b0, sb});
            end
            2'd1: begin
                n_dir_c = -$signed({1'b0, sb});
                n_dir_s = $signed({1'b0, cb});
            end
            2'd2: begin
                n_dir_c = -$signed({1'b0, cb});
                n_dir_s = -$signed({1'b0, sb});
            end
            default: begin
                n_dir_c = $signed({1'b0, sb});
                n_dir_s = -$signed({1'b0, cb});
            end
        endcase
    end

    // One multiplier, used for x then y
    always_comb begin
        mul_dir    = i_ctl.setup_x ? r_dir_c : r_dir_s;
        mul_centre = i_ctl.setup_x ? i_centre_x : i_centre_y;
        setup_p    = $signed({4'b0000, mul_centre, 11'b0})
                   + PW'(mul_dir * $signed({1'b0, i_rmax}))
                   + $signed(PW'(16384));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oct <= '0;
            r_rem <= '0;
        end else if (i_ctl.first) begin
            r_oct <= '0;
            r_rem <= '0;
        end else if (i_ctl.next) begin
            if (r_rem == IW'(OCT_STEPS - 1)) begin
                r_rem <= '0;
                r_oct <= r_oct + 1'b1;
            end else begin
                r_rem <= r_rem + 1'b1;
            end
        end
    end

    // Position registers; an inward step subtracts the direction
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_dir) begin
            r_dir_c <= n_dir_c;
            r_dir_s <= n_dir_s;
        end
        if (i_ctl.setup_x) begin
            r_px <= setup_p;
        end else if (i_ctl.step) begin
            r_px <= r_px - PW'(r_dir_c);
        end
        if (i_ctl.setup_y) begin
            r_py <= setup_p;
        end else if (i_ctl.step) begin
            r_py <= r_py - PW'(r_dir_s);
        end
    end

    assign in_x       = !r_px[PW-1] && (r_px[PW-2:15+XW] == '0);
    assign in_y       = !r_py[PW-1] && (r_py[PW-2:15+YW] == '0);
    assign o_in_frame = in_x && in_y;
    assign o_addr     = {r_py[15+YW-1:15], r_px[15+XW-1:15]};

endmodule
